### src/sntq_pkg.sv
// Shared types and constants for the sorted note timeout queue.
package sntq_pkg;

  localparam int ENTRIES_DEF  = 32;
  localparam int SECTIONS_DEF = 16;
  localparam logic [5:0] NIL  = 6'd63;

  typedef enum logic [2:0] {
    OP_ALLOC    = 3'd0,
    OP_SET_BASE = 3'd1,
    OP_SET_TIME = 3'd2,
    OP_EXPIRE   = 3'd3,
    OP_KEY_OFF  = 3'd4,
    OP_FREE     = 3'd5,
    OP_RESET    = 3'd6,
    OP_NOP      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_KOFF  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    TAG_ACT0 = 2'd0,
    TAG_ACT1 = 2'd1,
    TAG_COMP = 2'd2,
    TAG_FREE = 2'd3
  } tag_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] trigger_time;
    logic [3:0]         section;
    logic               time_base;
    logic signed [31:0] time_value;
    logic [31:0]        note_id;
    logic [5:0]         entry_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  entry;
    logic [31:0] key_id;
    logic        pending;
    logic        last;
  } out_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_A_TAKE,
    CMD_A_UNLINK,
    CMD_A_READ,
    CMD_A_STEP,
    CMD_A_LINK1,
    CMD_A_LINK2,
    CMD_X_READ,
    CMD_X_MOVE1,
    CMD_X_MOVE2,
    CMD_X_MOVE3,
    CMD_LI_NEXT,
    CMD_SET_BASE,
    CMD_SET_TIME,
    CMD_F_READ,
    CMD_F_UNLINK,
    CMD_F_PUSH,
    CMD_F_DONE,
    CMD_R_START,
    CMD_R_READ,
    CMD_R_STEP,
    CMD_R_LINK,
    CMD_EMIT_ALLOC,
    CMD_EMIT_EMPTY,
    CMD_EMIT_KOFF,
    CMD_EMIT_DONE
  } cmd_t;

  typedef struct packed {
    op_t        op;
    logic       head_nil;
    logic       free_nil;
    logic       cur_nil;
    logic       next_nil;
    logic       due_gt;
    logic       free_ok;
    logic [1:0] li;
    logic       slot_free;
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP,
    S_A0, S_A1, S_AW, S_AC, S_AL1, S_AL2, S_AE, S_EMPTY,
    S_X0, S_X1, S_X2, S_X3, S_XE, S_XN,
    S_SB, S_ST,
    S_F0, S_F1, S_F2, S_F3,
    S_R0, S_R1, S_R2, S_R3, S_RN,
    S_DONE
  } state_t;

endpackage

### src/sorted_note_timeout_queue_core.sv
// Top level of the sorted note timeout queue.
//
// Input channel in_valid/in_stall/in_data carries one operation per
// transfer; the result channel out_valid/out_stall/out_data returns one or
// more results per operation, the final one flagged by last.
// One operation is processed at a time; in_stall stays high from the
// transfer until its final result is loaded into the output register.
// Allocate walks its sorted list entry by entry to find the insertion point;
// expire and key off move entries from the heads of both active lists to
// the completed list, expire stopping at a head not yet due; free unlinks
// a valid completed entry and pushes it onto the free list; reset lists
// walks each non-empty list to its tail and splices it onto the free list.
// Throughput is set by the single read port of the link memory, which every
// list walk visits once per entry.
// A stalled receiver holds the result register and halts the sequence when it next has a result to load.
// Reset empties all lists but the free list, which then holds every entry
// in ascending order, and clears all section bases and clocks.
module sorted_note_timeout_queue_core #(
  parameter int ENTRIES  = sntq_pkg::ENTRIES_DEF,
  parameter int SECTIONS = sntq_pkg::SECTIONS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sntq_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sntq_pkg::out_t out_data
);
  import sntq_pkg::*;

  cmd_t    cmd;
  status_t st;

  sntq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  sntq_datapath #(
    .ENTRIES  (ENTRIES),
    .SECTIONS (SECTIONS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### src/sntq_ctrl.sv
// Controller state machine sequencing the list operations.
module sntq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sntq_pkg::status_t st,
  output sntq_pkg::cmd_t   cmd
);
  import sntq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st.op)
          OP_ALLOC:    state_nxt = S_A0;
          OP_SET_BASE: state_nxt = S_SB;
          OP_SET_TIME: state_nxt = S_ST;
          OP_EXPIRE,
          OP_KEY_OFF:  state_nxt = S_X0;
          OP_FREE:     state_nxt = S_F0;
          OP_RESET:    state_nxt = S_R0;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_A0: begin
        if (st.free_nil) state_nxt = S_EMPTY;
        else begin
          cmd       = CMD_A_TAKE;
          state_nxt = S_A1;
        end
      end
      S_A1: begin
        cmd       = CMD_A_UNLINK;
        state_nxt = S_AW;
      end
      S_AW: begin
        if (st.cur_nil) state_nxt = S_AL1;
        else begin
          cmd       = CMD_A_READ;
          state_nxt = S_AC;
        end
      end
      S_AC: begin
        if (st.due_gt) state_nxt = S_AL1;
        else begin
          cmd       = CMD_A_STEP;
          state_nxt = S_AW;
        end
      end
      S_AL1: begin
        cmd       = CMD_A_LINK1;
        state_nxt = S_AL2;
      end
      S_AL2: begin
        cmd       = CMD_A_LINK2;
        state_nxt = S_AE;
      end
      S_AE: begin
        if (st.slot_free) begin
          cmd       = CMD_EMIT_ALLOC;
          state_nxt = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (st.slot_free) begin
          cmd       = CMD_EMIT_EMPTY;
          state_nxt = S_IDLE;
        end
      end
      S_X0: begin
        if (st.head_nil) state_nxt = S_XN;
        else begin
          cmd       = CMD_X_READ;
          state_nxt = S_X1;
        end
      end
      S_X1: begin
        if (st.op == OP_EXPIRE && st.due_gt) state_nxt = S_XN;
        else begin
          cmd       = CMD_X_MOVE1;
          state_nxt = S_X2;
        end
      end
      S_X2: begin
        cmd       = CMD_X_MOVE2;
        state_nxt = S_X3;
      end
      S_X3: begin
        cmd       = CMD_X_MOVE3;
        state_nxt = S_XE;
      end
      S_XE: begin
        if (st.slot_free) begin
          cmd       = CMD_EMIT_KOFF;
          state_nxt = S_X0;
        end
      end
      S_XN: begin
        if (st.li == 2'd1) state_nxt = S_DONE;
        else begin
          cmd       = CMD_LI_NEXT;
          state_nxt = S_X0;
        end
      end
      S_SB: begin
        cmd       = CMD_SET_BASE;
        state_nxt = S_DONE;
      end
      S_ST: begin
        cmd       = CMD_SET_TIME;
        state_nxt = S_DONE;
      end
      S_F0: begin
        if (!st.free_ok) state_nxt = S_DONE;
        else begin
          cmd       = CMD_F_READ;
          state_nxt = S_F1;
        end
      end
      S_F1: begin
        cmd       = CMD_F_UNLINK;
        state_nxt = S_F2;
      end
      S_F2: begin
        cmd       = CMD_F_PUSH;
        state_nxt = S_F3;
      end
      S_F3: begin
        cmd       = CMD_F_DONE;
        state_nxt = S_DONE;
      end
      S_R0: begin
        if (st.head_nil) state_nxt = S_RN;
        else begin
          cmd       = CMD_R_START;
          state_nxt = S_R1;
        end
      end
      S_R1: begin
        cmd       = CMD_R_READ;
        state_nxt = S_R2;
      end
      S_R2: begin
        if (st.next_nil) state_nxt = S_R3;
        else begin
          cmd       = CMD_R_STEP;
          state_nxt = S_R1;
        end
      end
      S_R3: begin
        cmd       = CMD_R_LINK;
        state_nxt = S_RN;
      end
      S_RN: begin
        if (st.li == 2'd2) state_nxt = S_DONE;
        else begin
          cmd       = CMD_LI_NEXT;
          state_nxt = S_R0;
        end
      end
      S_DONE: begin
        if (st.slot_free) begin
          cmd       = CMD_EMIT_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### src/sntq_datapath.sv
// Datapath: entry memories, list heads, section clocks and result register.
module sntq_datapath #(
  parameter int ENTRIES  = sntq_pkg::ENTRIES_DEF,
  parameter int SECTIONS = sntq_pkg::SECTIONS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sntq_pkg::in_t     in_data,
  input  sntq_pkg::cmd_t    cmd,
  output sntq_pkg::status_t st,
  output logic              out_valid,
  input  logic              out_stall,
  output sntq_pkg::out_t    out_data
);
  import sntq_pkg::*;

  localparam int IW     = $clog2(ENTRIES);
  localparam int SEC_AW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  function automatic logic [15:0][3:0] build_sec_lut();
    logic [15:0][3:0] t;
    for (int i = 0; i < 16; i++) t[i] = 4'(i % SECTIONS);
    return t;
  endfunction

  localparam logic [15:0][3:0] SEC_LUT = build_sec_lut();

  // request and work registers
  in_t        req_r;
  logic [5:0] e_r, e_nxt;
  logic [5:0] cur_r, cur_nxt;
  logic [5:0] prv_r, prv_nxt;
  logic [1:0] li_r, li_nxt;
  logic [31:0] key_r, key_nxt;
  logic [5:0] head_r [3];
  logic [5:0] head_nxt [3];
  logic [5:0] free_r, free_nxt;
  tag_t       tag_r [ENTRIES];
  logic [SECTIONS-1:0] base_r;
  logic [31:0] clk_r [SECTIONS][2];

  // memories
  logic [5:0]        nxt_mem [ENTRIES];
  logic [5:0]        prv_mem [ENTRIES];
  logic [31:0]       due_mem [ENTRIES];
  logic [31:0]       id_mem  [ENTRIES];
  logic [SEC_AW-1:0] sec_mem [ENTRIES];
  logic [ENTRIES-1:0] nv_r, pv_r;

  logic [5:0]        nxt_q, prv_q, rda_q;
  logic [31:0]       due_q, id_q;
  logic [SEC_AW-1:0] sec_q;
  logic              nvq, pvq;

  logic              rd_en;
  logic [5:0]        rd_addr;
  logic              nw_en, pw_en, mw_en;
  logic [5:0]        nw_addr, nw_data, pw_addr, pw_data;
  logic              tag_we;
  logic [5:0]        tag_addr;
  tag_t              tag_val;
  logic              out_load;
  kind_t             out_kind;

  logic [SEC_AW-1:0] sec_red;
  logic [5:0]        rd_next, rd_prev, dflt_next;
  logic [31:0]       cmp_val;
  logic              slot_free;
  out_t              out_r;
  logic              out_valid_r;

  assign sec_red   = SEC_AW'(SEC_LUT[req_r.section]);
  assign dflt_next = ((7'({1'b0, rda_q}) + 7'd1) < 7'(ENTRIES)) ? rda_q + 6'd1 : NIL;
  assign rd_next   = nvq ? nxt_q : dflt_next;
  assign rd_prev   = pvq ? prv_q : NIL;
  assign cmp_val   = (op_t'(req_r.op) == OP_EXPIRE) ? clk_r[sec_q][li_r[0]]
                                                   : req_r.trigger_time;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    st.op        = op_t'(req_r.op);
    st.head_nil  = (head_r[li_r] == NIL);
    st.free_nil  = (free_r == NIL);
    st.cur_nil   = (cur_r == NIL);
    st.next_nil  = (rd_next == NIL);
    st.due_gt    = $signed(due_q) > $signed(cmp_val);
    st.free_ok   = (req_r.entry_index < 6'(ENTRIES)) &&
                   (tag_r[req_r.entry_index[IW-1:0]] == TAG_COMP);
    st.li        = li_r;
    st.slot_free = slot_free;
  end

  always_comb begin
    e_nxt    = e_r;
    cur_nxt  = cur_r;
    prv_nxt  = prv_r;
    li_nxt   = li_r;
    key_nxt  = key_r;
    free_nxt = free_r;
    for (int i = 0; i < 3; i++) head_nxt[i] = head_r[i];
    rd_en    = 1'b0;
    rd_addr  = e_r;
    nw_en    = 1'b0;
    nw_addr  = e_r;
    nw_data  = NIL;
    pw_en    = 1'b0;
    pw_addr  = e_r;
    pw_data  = NIL;
    mw_en    = 1'b0;
    tag_we   = 1'b0;
    tag_addr = e_r;
    tag_val  = TAG_FREE;
    out_load = 1'b0;
    out_kind = KIND_DONE;
    case (cmd)
      CMD_LOAD: li_nxt = 2'd0;
      CMD_A_TAKE: begin
        e_nxt    = free_r;
        rd_en    = 1'b1;
        rd_addr  = free_r;
        mw_en    = 1'b1;
        li_nxt   = {1'b0, base_r[sec_red]};
        tag_we   = 1'b1;
        tag_addr = free_r;
        tag_val  = tag_t'({1'b0, base_r[sec_red]});
      end
      CMD_A_UNLINK: begin
        free_nxt = rd_next;
        if (rd_next != NIL) begin
          pw_en   = 1'b1;
          pw_addr = rd_next;
          pw_data = NIL;
        end
        cur_nxt = head_r[li_r];
        prv_nxt = NIL;
      end
      CMD_A_READ: begin
        rd_en   = 1'b1;
        rd_addr = cur_r;
      end
      CMD_A_STEP: begin
        prv_nxt = cur_r;
        cur_nxt = rd_next;
      end
      CMD_A_LINK1: begin
        nw_en   = 1'b1;
        nw_addr = e_r;
        nw_data = cur_r;
        pw_en   = 1'b1;
        pw_addr = e_r;
        pw_data = prv_r;
      end
      CMD_A_LINK2: begin
        if (prv_r != NIL) begin
          nw_en   = 1'b1;
          nw_addr = prv_r;
          nw_data = e_r;
        end else begin
          head_nxt[li_r] = e_r;
        end
        if (cur_r != NIL) begin
          pw_en   = 1'b1;
          pw_addr = cur_r;
          pw_data = e_r;
        end
      end
      CMD_X_READ: begin
        e_nxt   = head_r[li_r];
        rd_en   = 1'b1;
        rd_addr = head_r[li_r];
      end
      CMD_X_MOVE1: begin
        head_nxt[li_r] = rd_next;
        if (rd_next != NIL) begin
          pw_en   = 1'b1;
          pw_addr = rd_next;
          pw_data = NIL;
        end
        nw_en   = 1'b1;
        nw_addr = e_r;
        nw_data = head_r[2];
        key_nxt = id_q;
      end
      CMD_X_MOVE2: begin
        pw_en   = 1'b1;
        pw_addr = e_r;
        pw_data = NIL;
      end
      CMD_X_MOVE3: begin
        if (head_r[2] != NIL) begin
          pw_en   = 1'b1;
          pw_addr = head_r[2];
          pw_data = e_r;
        end
        head_nxt[2] = e_r;
        tag_we      = 1'b1;
        tag_addr    = e_r;
        tag_val     = TAG_COMP;
      end
      CMD_LI_NEXT: li_nxt = li_r + 2'd1;
      CMD_F_READ: begin
        e_nxt   = req_r.entry_index;
        rd_en   = 1'b1;
        rd_addr = req_r.entry_index;
      end
      CMD_F_UNLINK: begin
        if (rd_next != NIL) begin
          pw_en   = 1'b1;
          pw_addr = rd_next;
          pw_data = rd_prev;
        end
        if (rd_prev != NIL) begin
          nw_en   = 1'b1;
          nw_addr = rd_prev;
          nw_data = rd_next;
        end else begin
          head_nxt[2] = rd_next;
        end
      end
      CMD_F_PUSH: begin
        nw_en   = 1'b1;
        nw_addr = e_r;
        nw_data = free_r;
        if (free_r != NIL) begin
          pw_en   = 1'b1;
          pw_addr = free_r;
          pw_data = e_r;
        end
      end
      CMD_F_DONE: begin
        pw_en    = 1'b1;
        pw_addr  = e_r;
        pw_data  = NIL;
        free_nxt = e_r;
        tag_we   = 1'b1;
        tag_addr = e_r;
        tag_val  = TAG_FREE;
      end
      CMD_R_START: cur_nxt = head_r[li_r];
      CMD_R_READ: begin
        rd_en    = 1'b1;
        rd_addr  = cur_r;
        tag_we   = 1'b1;
        tag_addr = cur_r;
        tag_val  = TAG_FREE;
      end
      CMD_R_STEP: cur_nxt = rd_next;
      CMD_R_LINK: begin
        if (free_r != NIL) begin
          nw_en   = 1'b1;
          nw_addr = cur_r;
          nw_data = free_r;
          pw_en   = 1'b1;
          pw_addr = free_r;
          pw_data = cur_r;
        end
        free_nxt       = head_r[li_r];
        head_nxt[li_r] = NIL;
      end
      CMD_EMIT_ALLOC: begin
        out_load = 1'b1;
        out_kind = KIND_ALLOC;
      end
      CMD_EMIT_EMPTY: begin
        out_load = 1'b1;
        out_kind = KIND_EMPTY;
      end
      CMD_EMIT_KOFF: begin
        out_load = 1'b1;
        out_kind = KIND_KOFF;
      end
      CMD_EMIT_DONE: begin
        out_load = 1'b1;
        out_kind = KIND_DONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) req_r <= in_data;
    e_r   <= e_nxt;
    cur_r <= cur_nxt;
    prv_r <= prv_nxt;
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      li_r   <= 2'd0;
      free_r <= 6'd0;
      for (int i = 0; i < 3; i++) head_r[i] <= NIL;
      for (int i = 0; i < ENTRIES; i++) tag_r[i] <= TAG_FREE;
      base_r <= '0;
      for (int i = 0; i < SECTIONS; i++) begin
        clk_r[i][0] <= '0;
        clk_r[i][1] <= '0;
      end
      nv_r <= '0;
      pv_r <= '0;
    end else begin
      li_r   <= li_nxt;
      free_r <= free_nxt;
      for (int i = 0; i < 3; i++) head_r[i] <= head_nxt[i];
      if (tag_we) tag_r[tag_addr[IW-1:0]] <= tag_val;
      if (cmd == CMD_SET_BASE) base_r[sec_red] <= req_r.time_base;
      if (cmd == CMD_SET_TIME) clk_r[sec_red][req_r.time_base] <= req_r.time_value;
      if (nw_en) nv_r[nw_addr[IW-1:0]] <= 1'b1;
      if (pw_en) pv_r[pw_addr[IW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (nw_en) nxt_mem[nw_addr[IW-1:0]] <= nw_data;
    if (pw_en) prv_mem[pw_addr[IW-1:0]] <= pw_data;
    if (mw_en) begin
      due_mem[e_nxt[IW-1:0]] <= req_r.trigger_time;
      id_mem[e_nxt[IW-1:0]]  <= req_r.note_id;
      sec_mem[e_nxt[IW-1:0]] <= sec_red;
    end
    if (rd_en) begin
      nxt_q <= nxt_mem[rd_addr[IW-1:0]];
      prv_q <= prv_mem[rd_addr[IW-1:0]];
      due_q <= due_mem[rd_addr[IW-1:0]];
      id_q  <= id_mem[rd_addr[IW-1:0]];
      sec_q <= sec_mem[rd_addr[IW-1:0]];
      nvq   <= nv_r[rd_addr[IW-1:0]];
      pvq   <= pv_r[rd_addr[IW-1:0]];
      rda_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.kind    <= out_kind;
      out_r.entry   <= (out_kind == KIND_ALLOC || out_kind == KIND_KOFF) ? e_r : 6'd0;
      out_r.key_id  <= (out_kind == KIND_KOFF) ? key_r : 32'd0;
      out_r.pending <= (head_r[0] != NIL) || (head_r[1] != NIL);
      out_r.last    <= (out_kind != KIND_KOFF);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### src/sntq_checker.sv
// Port-level checker for the sorted note timeout queue, bound to the top.
module sntq_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input sntq_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input sntq_pkg::out_t out_data
);
  import sntq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.kind == KIND_KOFF) == !out_data.last))
    else $error("last flag does not match result kind");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_DONE || out_data.kind == KIND_EMPTY)
    |-> out_data.entry == 6'd0 && out_data.key_id == 32'd0)
    else $error("nonzero entry on done or empty result");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new transfer taken while busy");

endmodule

bind sorted_note_timeout_queue_core sntq_checker u_sntq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/sorted_note_timeout_queue_core_test.sv
// Testbench for the sorted note timeout queue: random and directed operations checked against a predictor.
`timescale 1ns / 100ps
module sorted_note_timeout_queue_core_test;
  import sntq_pkg::*;

  localparam int NE = 32;
  localparam int NS = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  sorted_note_timeout_queue_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [31:0] due_q[NE];
  logic [3:0] sec_q[NE];
  logic [31:0] id_q[NE];
  logic [5:0] nxt[NE];
  logic [5:0] prv[NE];
  tag_t tag_q[NE];
  logic [5:0] heads[3];
  logic [5:0] free_hd;
  logic base_q[NS];
  logic signed [31:0] clk_q[NS*2];

  in_t pending_ops[$];
  out_t expected_results[$];
  int fails = 0;
  int cycles = 0;
  int hold_cnt = 0;
  int burst_left = 0;
  int gap_left = 0;

  function automatic bit lists_busy();
    return heads[0] != NIL || heads[1] != NIL;
  endfunction

  function automatic void push_result(kind_t k, logic [5:0] e, logic [31:0] id, logic lst);
    out_t r;
    r.kind = k; r.entry = e; r.key_id = id; r.pending = lists_busy(); r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_reset();
    for (int i = 0; i < NE; i++) begin
      nxt[i] = (i + 1 < NE) ? 6'(i + 1) : NIL;
      prv[i] = NIL;
      tag_q[i] = TAG_FREE;
    end
    for (int i = 0; i < NS; i++) base_q[i] = 1'b0;
    for (int i = 0; i < NS*2; i++) clk_q[i] = '0;
    heads[0] = NIL; heads[1] = NIL; heads[2] = NIL;
    free_hd = 6'd0;
  endfunction

  function automatic logic [5:0] retire_head(int li);
    logic [5:0] e, n;
    e = heads[li];
    n = nxt[e];
    heads[li] = n;
    if (n != NIL) prv[n] = NIL;
    n = heads[2];
    nxt[e] = n;
    prv[e] = NIL;
    if (n != NIL) prv[n] = e;
    heads[2] = e;
    tag_q[e] = TAG_COMP;
    return e;
  endfunction

  function automatic void splice_free(int li);
    logic [5:0] e;
    if (heads[li] == NIL) return;
    e = heads[li];
    forever begin
      tag_q[e] = TAG_FREE;
      if (nxt[e] == NIL) break;
      e = nxt[e];
    end
    if (free_hd != NIL) begin
      nxt[e] = free_hd;
      prv[free_hd] = e;
    end
    free_hd = heads[li];
    heads[li] = NIL;
  endfunction

  function automatic void predict_op(in_t it);
    logic [5:0] e, cur, pv, nx;
    int li, sec, cnt;
    sec = it.section % NS;
    cnt = 0;
    case (op_t'(it.op))
      OP_ALLOC: begin
        e = free_hd;
        if (e == NIL) begin
          push_result(KIND_EMPTY, '0, '0, 1'b1);
          return;
        end
        free_hd = nxt[e];
        if (free_hd != NIL) prv[free_hd] = NIL;
        due_q[e] = it.trigger_time;
        sec_q[e] = 4'(sec);
        id_q[e] = it.note_id;
        li = base_q[sec];
        tag_q[e] = tag_t'(li);
        cur = heads[li];
        pv = NIL;
        while (cur != NIL && due_q[cur] <= it.trigger_time) begin
          pv = cur;
          cur = nxt[cur];
        end
        nxt[e] = cur;
        prv[e] = pv;
        if (pv != NIL) nxt[pv] = e;
        else heads[li] = e;
        if (cur != NIL) prv[cur] = e;
        push_result(KIND_ALLOC, e, '0, 1'b1);
        return;
      end
      OP_SET_BASE: base_q[sec] = it.time_base;
      OP_SET_TIME: clk_q[sec*2 + it.time_base] = it.time_value;
      OP_EXPIRE, OP_KEY_OFF: begin
        for (li = 0; li < 2; li++) begin
          while (heads[li] != NIL && cnt < NE) begin
            e = heads[li];
            if (it.op == OP_EXPIRE && due_q[e] > clk_q[sec_q[e]*2 + li]) break;
            void'(retire_head(li));
            cnt++;
            push_result(KIND_KOFF, e, id_q[e], 1'b0);
          end
        end
      end
      OP_FREE: begin
        if (it.entry_index < NE && tag_q[it.entry_index] == TAG_COMP) begin
          e = it.entry_index;
          nx = nxt[e];
          pv = prv[e];
          if (nx != NIL) prv[nx] = pv;
          if (pv != NIL) nxt[pv] = nx;
          else heads[2] = nx;
          nxt[e] = free_hd;
          if (free_hd != NIL) prv[free_hd] = e;
          prv[e] = NIL;
          free_hd = e;
          tag_q[e] = TAG_FREE;
        end
      end
      OP_RESET: begin
        splice_free(0);
        splice_free(1);
        splice_free(2);
      end
      default: ;
    endcase
    push_result(KIND_DONE, '0, '0, 1'b1);
  endfunction

  function automatic in_t make_op(op_t op);
    in_t it;
    it.op = op;
    it.trigger_time = $urandom_range(0, 3) == 0 ? $urandom() : $signed($urandom_range(0, 60)) - 30;
    it.section = $urandom_range(0, 15);
    it.time_base = $urandom_range(0, 1);
    it.time_value = $urandom_range(0, 3) == 0 ? $urandom() : $signed($urandom_range(0, 60)) - 30;
    it.note_id = $urandom();
    it.entry_index = $urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(0, NE - 1);
    return it;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_op(in_data);
      end
      if (!(in_valid && in_stall)) begin
        if (pending_ops.size() > 0 && gap_left == 0) begin
          in_data <= pending_ops.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 8);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_t exp_r;
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d entry=%0d", out_data.kind, out_data.entry);
        fails++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.kind !== exp_r.kind) begin
          $error("kind: expected %0d actual %0d", exp_r.kind, out_data.kind); fails++;
        end
        if (out_data.entry !== exp_r.entry) begin
          $error("entry: expected %0d actual %0d", exp_r.entry, out_data.entry); fails++;
        end
        if (out_data.key_id !== exp_r.key_id) begin
          $error("key_id: expected %h actual %h", exp_r.key_id, out_data.key_id); fails++;
        end
        if (out_data.pending !== exp_r.pending) begin
          $error("pending: expected %0d actual %0d", exp_r.pending, out_data.pending); fails++;
        end
        if (out_data.last !== exp_r.last) begin
          $error("last: expected %0d actual %0d", exp_r.last, out_data.last); fails++;
        end
      end
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (cycles > 3000 && cycles < 3010) begin
      hold_cnt = 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ((cycles / 64) % 3 == 0) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("[sorted_note_timeout_queue_core] ERROR");
      $finish;
    end
  end

  initial begin
    in_t it;
    int n;
    predict_reset();
    it = make_op(OP_SET_TIME);
    it.section = 4'd15; it.time_base = 1'b1; it.time_value = 32'sh7fffffff;
    pending_ops.push_back(it);
    it = make_op(OP_SET_BASE);
    it.section = 4'd15; it.time_base = 1'b1;
    pending_ops.push_back(it);
    it = make_op(OP_ALLOC);
    it.section = 4'd15; it.trigger_time = 32'sh7fffffff; it.note_id = 32'hffffffff;
    pending_ops.push_back(it);
    it = make_op(OP_ALLOC);
    it.section = 4'd0; it.trigger_time = 32'sh80000000; it.note_id = 32'h0;
    pending_ops.push_back(it);
    it = make_op(OP_ALLOC);
    it.section = 4'd0; it.trigger_time = 32'sh80000000; it.note_id = 32'h5a5a5a5a;
    pending_ops.push_back(it);
    it = make_op(OP_EXPIRE);
    pending_ops.push_back(it);
    it = make_op(OP_FREE); it.entry_index = 6'd63; pending_ops.push_back(it);
    it = make_op(OP_FREE); it.entry_index = 6'd1; pending_ops.push_back(it);
    it = make_op(OP_FREE); it.entry_index = 6'd5; pending_ops.push_back(it);
    for (int i = 0; i < 34; i++) begin
      it = make_op(OP_ALLOC);
      pending_ops.push_back(it);
    end
    it = make_op(OP_KEY_OFF); pending_ops.push_back(it);
    it = make_op(OP_NOP); pending_ops.push_back(it);
    it = make_op(OP_RESET); pending_ops.push_back(it);
    it = make_op(OP_SET_BASE); it.section = 4'd15; it.time_base = 1'b0;
    pending_ops.push_back(it);
    n = 0;
    while (n < 163) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: it = make_op(OP_ALLOC);
        8: it = make_op(OP_SET_BASE);
        9, 10: it = make_op(OP_SET_TIME);
        11, 12, 13: it = make_op(OP_EXPIRE);
        14: it = make_op(OP_KEY_OFF);
        15, 16, 17: it = make_op(OP_FREE);
        18: it = make_op(OP_RESET);
        default: it = make_op(op_t'($urandom_range(0, 7)));
      endcase
      pending_ops.push_back(it);
      n++;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_ops.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (300) @(posedge clk);
    if (fails == 0 && expected_results.size() == 0) begin
      $display("[sorted_note_timeout_queue_core] OK");
    end else begin
      $display("[sorted_note_timeout_queue_core] ERROR");
    end
    $finish;
  end

endmodule

### sorted_note_timeout_queue_core.f
src/sntq_pkg.sv
src/sntq_ctrl.sv
src/sntq_datapath.sv
src/sorted_note_timeout_queue_core.sv
src/sntq_checker.sv
tb/sorted_note_timeout_queue_core_test.sv
